// ===== hw/rtl/irpd_pkg.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder package
// Shared widths, register map, reset values and types of the encoder.
// ----------------------------------------------------------------------------
package irpd_pkg;

    // Field widths.
    localparam int DUR_W  = 24;
    localparam int BYTE_W = 8;
    localparam int NIB_W  = 4;
    localparam int BIT_W  = 3;

    // Configuration port.
    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 5;
    localparam int REG_IDX_W  = 3;

    // Default depth of the queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    // Register indexes, one per 32-bit word.
    typedef enum logic [REG_IDX_W-1:0] {
        REG_HEADER_MARK  = 3'd0,
        REG_HEADER_SPACE = 3'd1,
        REG_BIT_MARK     = 3'd2,
        REG_ONE_SPACE    = 3'd3,
        REG_ZERO_SPACE   = 3'd4,
        REG_FOOTER_MARK  = 3'd5
    } reg_idx_t;

    // Reset values of the timing registers, in microseconds.
    localparam logic [DUR_W-1:0] RST_HEADER_MARK  = 24'd3740;
    localparam logic [DUR_W-1:0] RST_HEADER_SPACE = 24'd1940;
    localparam logic [DUR_W-1:0] RST_BIT_MARK     = 24'd440;
    localparam logic [DUR_W-1:0] RST_ONE_SPACE    = 24'd1430;
    localparam logic [DUR_W-1:0] RST_ZERO_SPACE   = 24'd490;
    localparam logic [DUR_W-1:0] RST_FOOTER_MARK  = 24'd450;

    // Timing configuration as seen by the back end.
    typedef struct packed {
        logic [DUR_W-1:0] header_mark;
        logic [DUR_W-1:0] header_space;
        logic [DUR_W-1:0] bit_mark;
        logic [DUR_W-1:0] one_space;
        logic [DUR_W-1:0] zero_space;
        logic [DUR_W-1:0] footer_mark;
    } cfg_t;

    // One classified byte, queued for transmission.
    typedef struct packed {
        logic [BYTE_W-1:0] data;
        logic              header;
        logic              last;
    } job_t;

    // Phases of the back-end sequencer.
    typedef enum logic [2:0] {
        PH_HDR_MARK,
        PH_HDR_SPACE,
        PH_BIT_MARK,
        PH_BIT_SPACE,
        PH_FOOTER
    } phase_t;

endpackage

// ===== hw/rtl/irpd_if.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder channels
// Valid/ready interfaces for the byte input and the mark/space output.
// ----------------------------------------------------------------------------
interface irpd_in_if;
    logic                          valid;
    logic                          ready;
    logic [irpd_pkg::BYTE_W-1:0]   frame_byte;
    logic                          last_byte;

    modport source (output valid, output frame_byte, output last_byte, input ready);
    modport sink   (input valid, input frame_byte, input last_byte, output ready);
endinterface

interface irpd_out_if;
    logic                          valid;
    logic                          ready;
    logic [irpd_pkg::DUR_W-1:0]    duration;
    logic                          is_pulse;
    logic                          last_of_run;
    logic                          end_of_frame;

    modport source (output valid, output duration, output is_pulse,
                    output last_of_run, output end_of_frame, input ready);
    modport sink   (input valid, input duration, input is_pulse,
                    input last_of_run, input end_of_frame, output ready);
endinterface

// ===== hw/rtl/ir_frame_pulse_distance_encoder.sv =====
// ----------------------------------------------------------------------------
// IR frame pulse-distance encoder
// Encodes frame bytes with a nibble-XOR checksum into timed marks and spaces.
//
//   Channel   Direction  Handshake      Payload
//   in_ch     sink       valid/ready    frame_byte[7:0], last_byte
//   out_ch    source     valid/ready    duration[23:0], is_pulse, last_of_run,
//                                       end_of_frame
//   apb       slave      psel/penable   paddr[4:0], pwdata/prdata[31:0]
//
// Each byte yields 16 results, plus 2 for the header of a new frame and 1 for
// the footer of the final byte; the back-end sequencer issues one per cycle
// while the output is not stalled, and chains into the next queued byte
// without a gap.
// Reset restores the default timings and starts outside a frame.
// A stalled output holds its register; the queue accepts bytes until it is full.
// ----------------------------------------------------------------------------
module ir_frame_pulse_distance_encoder
#(
    parameter int QUEUE_DEPTH = irpd_pkg::QUEUE_DEPTH
)
(
    input  logic                             clk,
    input  logic                             rst_n,
    irpd_in_if.sink                          in_ch,
    irpd_out_if.source                       out_ch,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready
);

    irpd_pkg::cfg_t  cfg;
    irpd_pkg::job_t  push_job;
    irpd_pkg::job_t  pop_job;
    logic            push_valid;
    logic            push_ready;
    logic            pop_valid;
    logic            pop_ready;

    // Timing registers.
    irpd_regs u_regs
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    // Byte intake and checksum.
    irpd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_ch      (in_ch),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job)
    );

    // Decoupling queue.
    irpd_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_job   (push_job),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_job    (pop_job)
    );

    // Mark/space sequencer.
    irpd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_job   (pop_job),
        .cfg       (cfg),
        .out_ch    (out_ch)
    );

endmodule

// ===== hw/rtl/irpd_regs.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder registers
// APB-style register file holding the six mark and space durations.
// ----------------------------------------------------------------------------
module irpd_regs
(
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             psel,
    input  logic                             penable,
    input  logic                             pwrite,
    input  logic [irpd_pkg::APB_ADDR_W-1:0]  paddr,
    input  logic [irpd_pkg::APB_DATA_W-1:0]  pwdata,
    output logic [irpd_pkg::APB_DATA_W-1:0]  prdata,
    output logic                             pready,
    output irpd_pkg::cfg_t                   cfg
);

    irpd_pkg::cfg_t                    cfg_reg;
    irpd_pkg::cfg_t                    cfg_next;
    logic                              wr_en;
    irpd_pkg::reg_idx_t                idx;
    logic [irpd_pkg::DUR_W-1:0]        rd_val;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = irpd_pkg::reg_idx_t'(paddr[irpd_pkg::APB_ADDR_W-1:2]);
    assign cfg    = cfg_reg;

    // Write decode; indexes past the map are dropped.
    always_comb
    begin
        cfg_next = cfg_reg;
        if (wr_en)
        begin
            unique case (idx)
                irpd_pkg::REG_HEADER_MARK:  cfg_next.header_mark  = pwdata[irpd_pkg::DUR_W-1:0];
                irpd_pkg::REG_HEADER_SPACE: cfg_next.header_space = pwdata[irpd_pkg::DUR_W-1:0];
                irpd_pkg::REG_BIT_MARK:     cfg_next.bit_mark     = pwdata[irpd_pkg::DUR_W-1:0];
                irpd_pkg::REG_ONE_SPACE:    cfg_next.one_space    = pwdata[irpd_pkg::DUR_W-1:0];
                irpd_pkg::REG_ZERO_SPACE:   cfg_next.zero_space   = pwdata[irpd_pkg::DUR_W-1:0];
                irpd_pkg::REG_FOOTER_MARK:  cfg_next.footer_mark  = pwdata[irpd_pkg::DUR_W-1:0];
                default:                    cfg_next = cfg_reg;
            endcase
        end
    end

    // Read decode.
    always_comb
    begin
        unique case (idx)
            irpd_pkg::REG_HEADER_MARK:  rd_val = cfg_reg.header_mark;
            irpd_pkg::REG_HEADER_SPACE: rd_val = cfg_reg.header_space;
            irpd_pkg::REG_BIT_MARK:     rd_val = cfg_reg.bit_mark;
            irpd_pkg::REG_ONE_SPACE:    rd_val = cfg_reg.one_space;
            irpd_pkg::REG_ZERO_SPACE:   rd_val = cfg_reg.zero_space;
            irpd_pkg::REG_FOOTER_MARK:  rd_val = cfg_reg.footer_mark;
            default:                    rd_val = '0;
        endcase
    end

    assign prdata = {{(irpd_pkg::APB_DATA_W - irpd_pkg::DUR_W){1'b0}}, rd_val};

    // Register storage with the standard timing defaults.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.header_mark  <= irpd_pkg::RST_HEADER_MARK;
            cfg_reg.header_space <= irpd_pkg::RST_HEADER_SPACE;
            cfg_reg.bit_mark     <= irpd_pkg::RST_BIT_MARK;
            cfg_reg.one_space    <= irpd_pkg::RST_ONE_SPACE;
            cfg_reg.zero_space   <= irpd_pkg::RST_ZERO_SPACE;
            cfg_reg.footer_mark  <= irpd_pkg::RST_FOOTER_MARK;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

endmodule

// ===== hw/rtl/irpd_front.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder front end
// Accepts frame bytes, tracks frame state and folds in the nibble checksum.
// ----------------------------------------------------------------------------
module irpd_front
(
    input  logic            clk,
    input  logic            rst_n,
    irpd_in_if.sink         in_ch,
    output logic            push_valid,
    input  logic            push_ready,
    output irpd_pkg::job_t  push_job
);

    logic [irpd_pkg::NIB_W-1:0] nibble_xor_reg;
    logic [irpd_pkg::NIB_W-1:0] nibble_xor_next;
    logic                       inside_frame_reg;
    logic                       inside_frame_next;
    logic                       accept;
    logic [irpd_pkg::NIB_W-1:0] hi;
    logic [irpd_pkg::NIB_W-1:0] lo;

    assign in_ch.ready = push_ready;
    assign push_valid  = in_ch.valid;
    assign accept      = in_ch.valid && push_ready;
    assign hi          = in_ch.frame_byte[7:4];
    assign lo          = in_ch.frame_byte[3:0];

    // Classify the byte: header needed, checksum merged into the final byte.
    always_comb
    begin
        push_job.header = !inside_frame_reg;
        push_job.last   = in_ch.last_byte;
        if (in_ch.last_byte)
        begin
            push_job.data = {hi, lo | (nibble_xor_reg ^ hi)};
        end
        else
        begin
            push_job.data = in_ch.frame_byte;
        end
    end

    // Frame state update on each accepted transaction.
    always_comb
    begin
        nibble_xor_next   = nibble_xor_reg;
        inside_frame_next = inside_frame_reg;
        if (accept)
        begin
            if (in_ch.last_byte)
            begin
                nibble_xor_next   = '0;
                inside_frame_next = 1'b0;
            end
            else
            begin
                nibble_xor_next   = nibble_xor_reg ^ hi ^ lo;
                inside_frame_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            nibble_xor_reg   <= '0;
            inside_frame_reg <= 1'b0;
        end
        else
        begin
            nibble_xor_reg   <= nibble_xor_next;
            inside_frame_reg <= inside_frame_next;
        end
    end

endmodule

// ===== hw/rtl/irpd_queue.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder job queue
// Small FIFO of classified bytes between the front and back ends.
// ----------------------------------------------------------------------------
module irpd_queue
#(
    parameter int DEPTH = irpd_pkg::QUEUE_DEPTH
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    output logic            push_ready,
    input  irpd_pkg::job_t  push_job,
    output logic            pop_valid,
    input  logic            pop_ready,
    output irpd_pkg::job_t  pop_job
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    irpd_pkg::job_t     mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_push;
    logic               do_pop;

    assign push_ready = (count_reg != CNT_W'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = mem[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    // Pointer and occupancy bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Entry storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== hw/rtl/irpd_back.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder back end
// Sequences header, bit and footer marks and spaces into a registered output.
// ----------------------------------------------------------------------------
module irpd_back
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  irpd_pkg::job_t  pop_job,
    input  irpd_pkg::cfg_t  cfg,
    irpd_out_if.source      out_ch
);

    irpd_pkg::phase_t               phase_reg;
    irpd_pkg::phase_t               phase_next;
    logic                           active_reg;
    logic                           active_next;
    logic [irpd_pkg::BIT_W-1:0]     bit_reg;
    logic [irpd_pkg::BIT_W-1:0]     bit_next;
    irpd_pkg::job_t                 job_reg;
    irpd_pkg::job_t                 job_next;

    logic                           out_valid_reg;
    logic                           out_valid_next;
    logic [irpd_pkg::DUR_W-1:0]     duration_reg;
    logic [irpd_pkg::DUR_W-1:0]     duration_next;
    logic                           is_pulse_reg;
    logic                           is_pulse_next;
    logic                           last_of_run_reg;
    logic                           last_of_run_next;
    logic                           end_of_frame_reg;
    logic                           end_of_frame_next;

    logic                           advance;
    logic                           job_done;
    logic                           load;
    logic [irpd_pkg::DUR_W-1:0]     cur_dur;
    logic                           cur_pulse;
    logic                           cur_fin;
    logic                           cur_eof;

    assign out_ch.valid        = out_valid_reg;
    assign out_ch.duration     = duration_reg;
    assign out_ch.is_pulse     = is_pulse_reg;
    assign out_ch.last_of_run  = last_of_run_reg;
    assign out_ch.end_of_frame = end_of_frame_reg;

    assign advance = active_reg && (!out_valid_reg || out_ch.ready);

    // Result of the current phase.
    always_comb
    begin
        cur_pulse = 1'b0;
        cur_fin   = 1'b0;
        cur_eof   = 1'b0;
        job_done  = 1'b0;
        unique case (phase_reg)
            irpd_pkg::PH_HDR_MARK:
            begin
                cur_dur   = cfg.header_mark;
                cur_pulse = 1'b1;
            end
            irpd_pkg::PH_HDR_SPACE:
            begin
                cur_dur = cfg.header_space;
            end
            irpd_pkg::PH_BIT_MARK:
            begin
                cur_dur   = cfg.bit_mark;
                cur_pulse = 1'b1;
            end
            irpd_pkg::PH_BIT_SPACE:
            begin
                cur_dur  = job_reg.data[bit_reg] ? cfg.one_space : cfg.zero_space;
                cur_fin  = (bit_reg == '0) && !job_reg.last;
                job_done = cur_fin;
            end
            irpd_pkg::PH_FOOTER:
            begin
                cur_dur   = cfg.footer_mark;
                cur_pulse = 1'b1;
                cur_fin   = 1'b1;
                cur_eof   = 1'b1;
                job_done  = 1'b1;
            end
            default:
            begin
                cur_dur = '0;
            end
        endcase
    end

    // Sequencer next state: step phases, chain straight into the next job.
    always_comb
    begin
        phase_next  = phase_reg;
        bit_next    = bit_reg;
        active_next = active_reg;
        job_next    = job_reg;
        load        = pop_valid && (!active_reg || (advance && job_done));

        if (advance)
        begin
            unique case (phase_reg)
                irpd_pkg::PH_HDR_MARK:  phase_next = irpd_pkg::PH_HDR_SPACE;
                irpd_pkg::PH_HDR_SPACE:
                begin
                    phase_next = irpd_pkg::PH_BIT_MARK;
                    bit_next   = '1;
                end
                irpd_pkg::PH_BIT_MARK:  phase_next = irpd_pkg::PH_BIT_SPACE;
                irpd_pkg::PH_BIT_SPACE:
                begin
                    if (bit_reg == '0)
                    begin
                        phase_next = irpd_pkg::PH_FOOTER;
                    end
                    else
                    begin
                        phase_next = irpd_pkg::PH_BIT_MARK;
                        bit_next   = bit_reg - 1'b1;
                    end
                end
                irpd_pkg::PH_FOOTER:    phase_next = irpd_pkg::PH_FOOTER;
                default:                phase_next = irpd_pkg::PH_HDR_MARK;
            endcase
            if (job_done)
            begin
                active_next = 1'b0;
            end
        end

        if (load)
        begin
            job_next    = pop_job;
            active_next = 1'b1;
            bit_next    = '1;
            phase_next  = pop_job.header ? irpd_pkg::PH_HDR_MARK : irpd_pkg::PH_BIT_MARK;
        end
    end

    assign pop_ready = load;

    // Output register: fill on advance, empty when the sink takes it.
    always_comb
    begin
        out_valid_next    = out_valid_reg;
        duration_next     = duration_reg;
        is_pulse_next     = is_pulse_reg;
        last_of_run_next  = last_of_run_reg;
        end_of_frame_next = end_of_frame_reg;
        if (advance)
        begin
            out_valid_next    = 1'b1;
            duration_next     = cur_dur;
            is_pulse_next     = cur_pulse;
            last_of_run_next  = cur_fin;
            end_of_frame_next = cur_eof;
        end
        else if (out_ch.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= irpd_pkg::PH_HDR_MARK;
            active_reg    <= 1'b0;
            bit_reg       <= '1;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            phase_reg     <= phase_next;
            active_reg    <= active_next;
            bit_reg       <= bit_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers carry no reset.
    always_ff @(posedge clk)
    begin
        job_reg          <= job_next;
        duration_reg     <= duration_next;
        is_pulse_reg     <= is_pulse_next;
        last_of_run_reg  <= last_of_run_next;
        end_of_frame_reg <= end_of_frame_next;
    end

endmodule

// ===== hw/rtl/irpd_checker.sv =====
// ----------------------------------------------------------------------------
// IR pulse-distance encoder checker
// Port-level assertions on the output stream, bound to the top level.
// ----------------------------------------------------------------------------
module irpd_checker
(
    input logic                          clk,
    input logic                          rst_n,
    input logic                          in_valid,
    input logic                          in_ready,
    input logic                          out_valid,
    input logic                          out_ready,
    input logic [irpd_pkg::DUR_W-1:0]    out_duration,
    input logic                          out_is_pulse,
    input logic                          out_last_of_run,
    input logic                          out_end_of_frame
);

    logic seen_in_reg;
    logic after_eof_reg;
    logic out_xact;

    assign out_xact = out_valid && out_ready;

    // Track whether any byte arrived and whether the previous result ended a frame.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seen_in_reg   <= 1'b0;
            after_eof_reg <= 1'b1;
        end
        else
        begin
            if (in_valid && in_ready)
            begin
                seen_in_reg <= 1'b1;
            end
            if (out_xact)
            begin
                after_eof_reg <= out_end_of_frame;
            end
        end
    end

    // A pending result holds until it is taken.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_duration))
        else $error("output result dropped or changed while stalled");

    // No result appears before any byte was accepted.
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> seen_in_reg)
        else $error("result without any accepted byte");

    // The footer is a closing mark.
    a_footer_shape: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_end_of_frame |-> out_is_pulse && out_last_of_run)
        else $error("footer is not a closing mark");

    // A byte that does not close the frame ends on a space.
    a_run_end_space: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_last_of_run && !out_end_of_frame |-> !out_is_pulse)
        else $error("run ended on a mark outside a footer");

    // A frame opens with a header mark.
    a_frame_opens: assert property (@(posedge clk) disable iff (!rst_n)
        out_xact && after_eof_reg |-> out_is_pulse && !out_last_of_run)
        else $error("frame does not open with a header mark");

endmodule

bind ir_frame_pulse_distance_encoder irpd_checker u_checker
(
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_ch.valid),
    .in_ready         (in_ch.ready),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_duration     (out_ch.duration),
    .out_is_pulse     (out_ch.is_pulse),
    .out_last_of_run  (out_ch.last_of_run),
    .out_end_of_frame (out_ch.end_of_frame)
);

// ===== tb/testbench.sv =====
// ----------------------------------------------------------------------------
// IR frame pulse-distance encoder testbench
// Sends frames of bytes through the encoder under several timing settings and
// checks every mark and space against a local model of the frame encoding.
// ----------------------------------------------------------------------------
module testbench;

    // Register slots past the end of the map; writes there must be ignored.
    localparam logic [irpd_pkg::REG_IDX_W-1:0] REG_SPARE_A = 3'd6;
    localparam logic [irpd_pkg::REG_IDX_W-1:0] REG_SPARE_B = 3'd7;
    localparam int NUM_TIMINGS = 6;
    localparam int IDLE_PERCENT = 18;

    typedef struct packed {
        logic [irpd_pkg::BYTE_W-1:0] data;
        logic                        last;
    } frame_item_t;

    typedef struct packed {
        logic [irpd_pkg::DUR_W-1:0] duration;
        logic                       is_pulse;
        logic                       last_of_run;
        logic                       end_of_frame;
    } mark_space_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                            psel = 1'b0;
    logic                            penable = 1'b0;
    logic                            pwrite = 1'b0;
    logic [irpd_pkg::APB_ADDR_W-1:0] paddr = '0;
    logic [irpd_pkg::APB_DATA_W-1:0] pwdata = '0;
    logic [irpd_pkg::APB_DATA_W-1:0] prdata;
    logic                            pready;

    irpd_in_if  in_ch ();
    irpd_out_if out_ch ();

    ir_frame_pulse_distance_encoder dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_ch   (in_ch),
        .out_ch  (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Bytes waiting to be sent and the marks and spaces they must produce.
    frame_item_t pending_bytes[$];
    mark_space_t expected_marks[$];

    // Local copy of the timing registers and the checksum state.
    logic [irpd_pkg::DUR_W-1:0] timing [NUM_TIMINGS];
    logic [irpd_pkg::NIB_W-1:0] running_xor = '0;
    logic                       in_frame = 1'b0;

    logic steady_flow = 1'b0;
    int   error_count = 0;
    int   bytes_sent = 0;
    int   marks_checked = 0;
    int   frames_queued = 0;
    int   reg_writes = 0;

    // Clock with a period of two time units.
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    task automatic report_mismatch(input string msg);
    begin
        $display("MISMATCH: %s", msg);
        error_count++;
    end
    endtask

    task automatic push_mark(input logic [irpd_pkg::DUR_W-1:0] dur, input logic pulse,
                             input logic run_end, input logic frame_end);
        mark_space_t m;
    begin
        m.duration = dur;
        m.is_pulse = pulse;
        m.last_of_run = run_end;
        m.end_of_frame = frame_end;
        expected_marks.push_back(m);
    end
    endtask

    // Expected marks and spaces for one accepted byte.
    task automatic encode_frame_byte(input logic [irpd_pkg::BYTE_W-1:0] data,
                                     input logic last);
        logic [irpd_pkg::BYTE_W-1:0] sent;
        logic [irpd_pkg::NIB_W-1:0]  hi;
        logic [irpd_pkg::NIB_W-1:0]  lo;
    begin
        hi = data[7:4];
        lo = data[3:0];
        sent = data;
        if (!in_frame)
        begin
            push_mark(timing[irpd_pkg::REG_HEADER_MARK], 1'b1, 1'b0, 1'b0);
            push_mark(timing[irpd_pkg::REG_HEADER_SPACE], 1'b0, 1'b0, 1'b0);
            in_frame = 1'b1;
        end
        // The final byte carries the checksum in its low nibble.
        if (last)
            sent[3:0] = lo | (running_xor ^ hi);
        else
            running_xor = running_xor ^ hi ^ lo;
        for (int i = irpd_pkg::BYTE_W - 1; i >= 0; i--)
        begin
            push_mark(timing[irpd_pkg::REG_BIT_MARK], 1'b1, 1'b0, 1'b0);
            push_mark(sent[i] ? timing[irpd_pkg::REG_ONE_SPACE]
                              : timing[irpd_pkg::REG_ZERO_SPACE], 1'b0,
                      !last && (i == 0), 1'b0);
        end
        if (last)
        begin
            push_mark(timing[irpd_pkg::REG_FOOTER_MARK], 1'b1, 1'b1, 1'b1);
            running_xor = '0;
            in_frame = 1'b0;
        end
    end
    endtask

    // Input driver: takes the next pending byte once the slot is free.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_ch.valid <= 1'b0;
            in_ch.frame_byte <= '0;
            in_ch.last_byte <= 1'b0;
        end
        else if (!in_ch.valid || in_ch.ready)
        begin
            if (pending_bytes.size() > 0 &&
                (steady_flow || $urandom_range(99) >= IDLE_PERCENT))
            begin
                frame_item_t item;
                item = pending_bytes.pop_front();
                in_ch.valid <= 1'b1;
                in_ch.frame_byte <= item.data;
                in_ch.last_byte <= item.last;
            end
            else
                in_ch.valid <= 1'b0;
        end
    end

    // Output back-pressure.
    always @(posedge clk)
    begin
        out_ch.ready <= steady_flow || ($urandom_range(99) >= IDLE_PERCENT);
    end

    // Input monitor: predict the results of every accepted byte.
    always @(posedge clk)
    begin
        if (rst_n && in_ch.valid && in_ch.ready)
        begin
            encode_frame_byte(in_ch.frame_byte, in_ch.last_byte);
            bytes_sent++;
        end
    end

    // Output monitor: each transaction is checked against the oldest expectation.
    always @(posedge clk)
    begin
        if (rst_n && out_ch.valid && out_ch.ready)
        begin
            mark_space_t got;
            mark_space_t want;
            got.duration = out_ch.duration;
            got.is_pulse = out_ch.is_pulse;
            got.last_of_run = out_ch.last_of_run;
            got.end_of_frame = out_ch.end_of_frame;
            marks_checked++;
            if (expected_marks.size() == 0)
                report_mismatch($sformatf("unexpected result dur=%0d pulse=%b run=%b eof=%b",
                    got.duration, got.is_pulse, got.last_of_run, got.end_of_frame));
            else
            begin
                want = expected_marks.pop_front();
                if (got !== want)
                    report_mismatch($sformatf(
                        "result %0d: got %0d/%b/%b/%b, want %0d/%b/%b/%b",
                        marks_checked, got.duration, got.is_pulse, got.last_of_run,
                        got.end_of_frame, want.duration, want.is_pulse, want.last_of_run,
                        want.end_of_frame));
            end
        end
    end

    // Register write: setup cycle, then access cycle until pready.
    task automatic reg_write(input logic [irpd_pkg::REG_IDX_W-1:0] idx,
                             input logic [irpd_pkg::APB_DATA_W-1:0] value);
    begin
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= irpd_pkg::APB_ADDR_W'(idx) << 2;
        pwdata <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        if (idx <= irpd_pkg::REG_FOOTER_MARK)
            timing[idx] = value[irpd_pkg::DUR_W-1:0];
        reg_writes++;
    end
    endtask

    // Register read-back against the local copy.
    task automatic reg_check(input logic [irpd_pkg::REG_IDX_W-1:0] idx);
    begin
        @(posedge clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b0;
        paddr <= irpd_pkg::APB_ADDR_W'(idx) << 2;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        if (prdata[irpd_pkg::DUR_W-1:0] !== timing[idx])
            report_mismatch($sformatf("register %0d reads %0d, want %0d",
                idx, prdata[irpd_pkg::DUR_W-1:0], timing[idx]));
        psel <= 1'b0;
        penable <= 1'b0;
    end
    endtask

    // Set all six timings and read them back.
    task automatic set_timings(input logic [irpd_pkg::APB_DATA_W-1:0] values [NUM_TIMINGS]);
    begin
        for (int r = 0; r < NUM_TIMINGS; r++)
            reg_write(irpd_pkg::REG_IDX_W'(r), values[r]);
        for (int r = 0; r < NUM_TIMINGS; r++)
            reg_check(irpd_pkg::REG_IDX_W'(r));
    end
    endtask

    // Wait until every byte is sent and every expected result has arrived.
    task automatic wait_drained(input int settle);
    begin
        do @(posedge clk);
        while (pending_bytes.size() > 0 || in_ch.valid || expected_marks.size() > 0);
        repeat (settle) @(posedge clk);
    end
    endtask

    task automatic queue_byte(input logic [irpd_pkg::BYTE_W-1:0] data, input logic last);
        frame_item_t item;
    begin
        item.data = data;
        item.last = last;
        pending_bytes.push_back(item);
        if (last)
            frames_queued++;
    end
    endtask

    // One well-formed frame of random content; the final low nibble is usually clear.
    task automatic queue_random_frame(input int len);
        logic [irpd_pkg::BYTE_W-1:0] tail;
    begin
        for (int i = 0; i < len - 1; i++)
            queue_byte(irpd_pkg::BYTE_W'($urandom), 1'b0);
        tail = irpd_pkg::BYTE_W'($urandom);
        if ($urandom_range(3) != 0)
            tail[3:0] = '0;
        queue_byte(tail, 1'b1);
    end
    endtask

    task automatic queue_random_bytes(input int count);
        int queued;
        int len;
    begin
        queued = 0;
        while (queued < count)
        begin
            len = ($urandom_range(9) == 0) ? $urandom_range(7, 12) : $urandom_range(1, 5);
            queue_random_frame(len);
            queued += len;
        end
    end
    endtask

    // Random timing: realistic values half the time, else tiny values or full range.
    function automatic logic [irpd_pkg::APB_DATA_W-1:0] random_timing();
        logic [irpd_pkg::APB_DATA_W-1:0] v;
    begin
        case ($urandom_range(3))
            0: v = $urandom;
            1: v = $urandom_range(0, 16);
            default: v = $urandom_range(100, 10000);
        endcase
        return v;
    end
    endfunction

    // Reset, directed frames, then random frames under several timing settings.
    initial
    begin
        logic [irpd_pkg::APB_DATA_W-1:0] values [NUM_TIMINGS];

        timing[irpd_pkg::REG_HEADER_MARK] = irpd_pkg::RST_HEADER_MARK;
        timing[irpd_pkg::REG_HEADER_SPACE] = irpd_pkg::RST_HEADER_SPACE;
        timing[irpd_pkg::REG_BIT_MARK] = irpd_pkg::RST_BIT_MARK;
        timing[irpd_pkg::REG_ONE_SPACE] = irpd_pkg::RST_ONE_SPACE;
        timing[irpd_pkg::REG_ZERO_SPACE] = irpd_pkg::RST_ZERO_SPACE;
        timing[irpd_pkg::REG_FOOTER_MARK] = irpd_pkg::RST_FOOTER_MARK;

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Reset values must read back before anything is written.
        for (int r = 0; r < NUM_TIMINGS; r++)
            reg_check(irpd_pkg::REG_IDX_W'(r));

        // Single-byte frames, including a final byte with its low nibble set.
        queue_byte(8'h00, 1'b1);
        queue_byte(8'hF0, 1'b1);
        queue_byte(8'hFF, 1'b1);
        queue_byte(8'hA5, 1'b1);
        // Multi-byte frames with extreme bytes.
        queue_byte(8'h00, 1'b0);
        queue_byte(8'hFF, 1'b0);
        queue_byte(8'h80, 1'b0);
        queue_byte(8'h01, 1'b0);
        queue_byte(8'h70, 1'b1);
        queue_byte(8'h12, 1'b0);
        queue_byte(8'h34, 1'b0);
        queue_byte(8'h5F, 1'b1);
        queue_byte(8'hC3, 1'b0);
        queue_byte(8'h00, 1'b1);
        wait_drained(4);

        // All timings at their maximum, with junk above the register width.
        for (int r = 0; r < NUM_TIMINGS; r++)
            values[r] = 32'hFFFF_FFFF;
        set_timings(values);
        queue_random_bytes(30);
        wait_drained(4);

        // All timings zero; the output runs without stalls or gaps here.
        for (int r = 0; r < NUM_TIMINGS; r++)
            values[r] = 32'h0;
        set_timings(values);
        steady_flow <= 1'b1;
        queue_random_bytes(30);
        wait_drained(4);
        steady_flow <= 1'b0;

        // Random timings; writes past the register map must change nothing.
        for (int phase = 0; phase < 3; phase++)
        begin
            for (int r = 0; r < NUM_TIMINGS; r++)
                values[r] = random_timing();
            set_timings(values);
            reg_write(REG_SPARE_A, $urandom);
            reg_write(REG_SPARE_B, $urandom);
            for (int r = 0; r < NUM_TIMINGS; r++)
                reg_check(irpd_pkg::REG_IDX_W'(r));
            queue_random_bytes(30);
            wait_drained(4);
        end

        wait_drained(20);
        $display("Sent %0d bytes in %0d frames, checked %0d marks and spaces,",
                 bytes_sent, frames_queued, marks_checked);
        $display("across %0d register writes with %0d mismatches.", reg_writes, error_count);
        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    // Watchdog.
    initial
    begin
        #400000;
        $display("Timeout with %0d results still expected.", expected_marks.size());
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/irpd_pkg.sv
hw/rtl/irpd_if.sv
hw/rtl/irpd_regs.sv
hw/rtl/irpd_front.sv
hw/rtl/irpd_queue.sv
hw/rtl/irpd_back.sv
hw/rtl/ir_frame_pulse_distance_encoder.sv
hw/rtl/irpd_checker.sv
tb/testbench.sv
